@@ rtl/core/pts_pkg.sv @@
package pts_pkg;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_FINISH
    } t_state;

    localparam logic [1:0] OP_CREATE   = 2'd0;
    localparam logic [1:0] OP_TICK     = 2'd1;
    localparam logic [1:0] OP_DISPATCH = 2'd2;
    localparam logic [1:0] OP_UNUSED   = 2'd3;

    localparam logic [1:0] KIND_CREATE = 2'd0;
    localparam logic [1:0] KIND_TICK   = 2'd1;
    localparam logic [1:0] KIND_DISP   = 2'd2;
    localparam logic [1:0] KIND_NONE   = 2'd3;

    localparam logic [1:0] CST_OK      = 2'd0;
    localparam logic [1:0] CST_NOFUNC  = 2'd1;
    localparam logic [1:0] CST_PERIOD  = 2'd2;
    localparam logic [1:0] CST_FULL    = 2'd3;

    localparam logic [1:0] TS_SUSPENDED = 2'd0;
    localparam logic [1:0] TS_READY     = 2'd1;
    localparam logic [1:0] TS_BLOCKED   = 2'd2;
    localparam logic [1:0] TS_UNUSED    = 2'd3;

    localparam int CNT_W = 18;

    // broadcast control from the sequencer to every cell
    typedef struct packed {
        logic        adv;     // token cell acts this cycle
        logic        shift;   // token moves one cell
        logic        flush;   // token is dropped
        logic        inject;  // token enters cell 0 on shift
        logic        tick;
        logic        disp;
        logic [15:0] step;
    } t_cell_ctl;

    typedef struct packed {
        logic [15:0]      period;
        logic [7:0]       delay;
        logic [1:0]       status;
        logic [CNT_W-1:0] cnt;
    } t_cell_wr;

endpackage

@@ rtl/core/pts_cell.sv @@
module pts_cell
    import pts_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cell_ctl i_ctl,
    input  logic      i_wr_en,
    input  t_cell_wr  i_wr,
    input  logic      i_tok,
    output logic      o_tok,
    output logic      o_hit
);

    logic [15:0]      r_period;
    logic [7:0]       r_delay;
    logic [1:0]       r_status;
    logic [CNT_W-1:0] r_cnt;
    logic             r_tok;
    logic             act;

    assign act   = r_tok && i_ctl.adv;
    assign o_tok = r_tok;
    assign o_hit = act && i_ctl.disp && (r_status == TS_READY);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= 1'b0;
        end else if (i_ctl.flush) begin
            r_tok <= 1'b0;
        end else if (i_ctl.shift) begin
            r_tok <= i_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_period <= i_wr.period;
            r_delay  <= i_wr.delay;
            r_status <= i_wr.status;
            r_cnt    <= i_wr.cnt;
        end else if (act && i_ctl.tick && (r_status != TS_SUSPENDED)) begin
            if (r_cnt >= CNT_W'(r_period)) begin
                r_status <= TS_READY;
                r_cnt    <= CNT_W'(i_ctl.step) + CNT_W'(r_delay);
            end else begin
                r_cnt    <= r_cnt + CNT_W'(i_ctl.step);
            end
        end else if (o_hit) begin
            r_status <= TS_BLOCKED;
        end
    end

endmodule

@@ rtl/core/periodic_task_scheduler_top.sv @@
// channel  | handshake                  | payload
// ---------+----------------------------+-------------------------------------------
// in       | i_in_valid / o_in_stall    | i_op i_has_function i_period
//          |                            | i_initial_state i_extra_delay
// out      | o_out_valid / i_out_stall  | o_kind o_status o_task_id o_last
// cfg      | i_cfg_we                   | i_cfg_index i_cfg_data
//
// Create goes from idle straight to the finish state. Tick and dispatch: a token
// walks the cell row one cell per cycle, but a stalled output register freezes
// the walk; with no tasks the walk is skipped. Input is taken only in the idle
// state. Reset is synchronous; task entries hold garbage until created.
module periodic_task_scheduler_top
    import pts_pkg::*;
#(
    parameter int MAX_TASKS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_op,
    input  logic        i_has_function,
    input  logic [15:0] i_period,
    input  logic [1:0]  i_initial_state,
    input  logic [7:0]  i_extra_delay,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_kind,
    output logic [1:0]  o_status,
    output logic [2:0]  o_task_id,
    output logic        o_last,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    localparam int IW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int CW = $clog2(MAX_TASKS + 1);

    localparam logic CFG_TICK_STEP = 1'b0;
    localparam logic CFG_HYPER     = 1'b1;

    t_state r_state, n_state;

    logic [15:0]   r_tick_step;
    logic [15:0]   r_hyper;
    logic [CW-1:0] r_task_count;
    logic [1:0]    r_op;
    logic [IW-1:0] r_idx;
    logic          r_pend_vld;
    logic [IW-1:0] r_pend_id;
    logic [1:0]    r_res_kind;
    logic [1:0]    r_res_status;
    logic [2:0]    r_res_id;

    logic          r_out_vld;
    logic [1:0]    r_out_kind;
    logic [1:0]    r_out_status;
    logic [2:0]    r_out_id;
    logic          r_out_last;

    logic          accept;
    logic          out_free;
    logic          walk_last;
    logic          hit;
    logic          adv;
    logic          emit_mid;
    logic          emit_fin;
    logic          start_walk;
    logic [1:0]    cr_status;
    logic          cr_ok;

    t_cell_ctl     ctl;
    t_cell_wr      wr;
    logic [MAX_TASKS-1:0] wr_en;
    logic [MAX_TASKS-1:0] hits;
    logic [MAX_TASKS:0]   tok;

    assign accept    = i_in_valid && !o_in_stall;
    assign out_free  = !r_out_vld || !i_out_stall;
    assign walk_last = (r_idx == IW'(r_task_count - CW'(1)));
    assign hit       = |hits;

    // create checks in priority order
    always_comb begin
        if (!i_has_function) begin
            cr_status = CST_NOFUNC;
        end else if (i_period > r_hyper) begin
            cr_status = CST_PERIOD;
        end else if (r_task_count >= CW'(MAX_TASKS)) begin
            cr_status = CST_FULL;
        end else begin
            cr_status = CST_OK;
        end
    end
    assign cr_ok = (cr_status == CST_OK);

    assign start_walk = accept && (i_op inside {OP_TICK, OP_DISPATCH})
                        && (r_task_count != '0);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (start_walk) begin
                        n_state = S_WALK;
                    end else if (i_op != OP_UNUSED) begin
                        n_state = S_FINISH;
                    end
                end
            end
            S_WALK: begin
                if (adv && walk_last) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        o_in_stall = 1'b1;
        adv        = 1'b0;
        emit_mid   = 1'b0;
        emit_fin   = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
            end
            S_WALK: begin
                adv      = out_free;
                emit_mid = out_free && hit && r_pend_vld;
            end
            S_FINISH: begin
                emit_fin = out_free;
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

    always_comb begin
        ctl.adv    = adv;
        ctl.shift  = start_walk || (adv && !walk_last);
        ctl.flush  = adv && walk_last;
        ctl.inject = start_walk;
        ctl.tick   = (r_op == OP_TICK);
        ctl.disp   = (r_op == OP_DISPATCH);
        ctl.step   = r_tick_step;
        wr.period  = i_period;
        wr.delay   = i_extra_delay;
        wr.status  = (i_initial_state == TS_UNUSED) ? TS_BLOCKED : i_initial_state;
        wr.cnt     = CNT_W'(r_tick_step);
    end

    assign tok[0] = ctl.inject;

    for (genvar g = 0; g < MAX_TASKS; g++) begin : g_cell
        assign wr_en[g] = accept && (i_op == OP_CREATE) && cr_ok
                          && (r_task_count == CW'(g));
        pts_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (ctl),
            .i_wr_en (wr_en[g]),
            .i_wr    (wr),
            .i_tok   (tok[g]),
            .o_tok   (tok[g+1]),
            .o_hit   (hits[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_tick_step  <= 16'd1;
            r_hyper      <= 16'hFFFF;
            r_task_count <= '0;
            r_pend_vld   <= 1'b0;
            r_out_vld    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_TICK_STEP) begin
                    r_tick_step <= i_cfg_data;
                end else if (i_cfg_index == CFG_HYPER) begin
                    r_hyper <= i_cfg_data;
                end
            end
            if (accept && (i_op == OP_CREATE) && cr_ok) begin
                r_task_count <= r_task_count + CW'(1);
            end
            if (accept) begin
                r_pend_vld <= 1'b0;
            end else if (adv && hit) begin
                r_pend_vld <= 1'b1;
            end
            if (emit_mid || emit_fin) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op  <= i_op;
            r_idx <= '0;
            case (i_op)
                OP_CREATE: begin
                    r_res_kind   <= KIND_CREATE;
                    r_res_status <= cr_status;
                    r_res_id     <= cr_ok ? 3'(r_task_count) : 3'd0;
                end
                OP_TICK: begin
                    r_res_kind   <= KIND_TICK;
                    r_res_status <= CST_OK;
                    r_res_id     <= 3'd0;
                end
                default: begin
                    r_res_kind   <= KIND_NONE;
                    r_res_status <= CST_OK;
                    r_res_id     <= 3'd0;
                end
            endcase
        end else if (adv) begin
            r_idx <= r_idx + IW'(1);
            if (hit) begin
                r_pend_id <= r_idx;
            end
            if (walk_last) begin
                r_res_status <= CST_OK;
                if (r_op == OP_TICK) begin
                    r_res_kind <= KIND_TICK;
                    r_res_id   <= 3'd0;
                end else if (hit) begin
                    r_res_kind <= KIND_DISP;
                    r_res_id   <= 3'(r_idx);
                end else if (r_pend_vld) begin
                    r_res_kind <= KIND_DISP;
                    r_res_id   <= 3'(r_pend_id);
                end else begin
                    r_res_kind <= KIND_NONE;
                    r_res_id   <= 3'd0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit_fin) begin
            r_out_kind   <= r_res_kind;
            r_out_status <= r_res_status;
            r_out_id     <= r_res_id;
            r_out_last   <= 1'b1;
        end else if (emit_mid) begin
            // earlier ready task, a later one is known to follow
            r_out_kind   <= KIND_DISP;
            r_out_status <= CST_OK;
            r_out_id     <= 3'(r_pend_id);
            r_out_last   <= 1'b0;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_kind      = r_out_kind;
    assign o_status    = r_out_status;
    assign o_task_id   = r_out_id;
    assign o_last      = r_out_last;

endmodule

@@ test/tb.sv @@
`timescale 1ns / 100ps

module tb;
    import pts_pkg::*;

    localparam int MAX_TASKS    = 8;
    localparam int DRAIN_CYCLES = MAX_TASKS + 8;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int PHASE_ITEMS  = 40;

    localparam logic       REG_TICK_STEP = 1'b0;
    localparam logic       REG_HYPER     = 1'b1;

    typedef struct packed {
        logic [1:0]  op;
        logic        fn;
        logic [15:0] period;
        logic [1:0]  init;
        logic [7:0]  delay;
    } t_item;

    typedef struct packed {
        logic [1:0] kind;
        logic [1:0] status;
        logic [2:0] id;
        logic       last;
    } t_result;

    typedef struct packed {
        bit          is_cfg;
        logic        cfg_idx;
        logic [15:0] cfg_data;
        t_item       it;
        bit          typed;
        t_result     want;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [1:0]  i_op;
    logic        i_has_function;
    logic [15:0] i_period;
    logic [1:0]  i_initial_state;
    logic [7:0]  i_extra_delay;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [1:0]  o_kind;
    logic [1:0]  o_status;
    logic [2:0]  o_task_id;
    logic        o_last;
    logic        i_cfg_we;
    logic        i_cfg_index;
    logic [15:0] i_cfg_data;

    periodic_task_scheduler_top #(
        .MAX_TASKS(MAX_TASKS)
    ) u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_op           (i_op),
        .i_has_function (i_has_function),
        .i_period       (i_period),
        .i_initial_state(i_initial_state),
        .i_extra_delay  (i_extra_delay),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_kind         (o_kind),
        .o_status       (o_status),
        .o_task_id      (o_task_id),
        .o_last         (o_last),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    // scheduler shadow state
    logic [15:0] tick_step_reg;
    logic [15:0] hyper_reg;
    int          n_tasks;
    logic [15:0] sh_period [MAX_TASKS];
    logic [7:0]  sh_delay  [MAX_TASKS];
    logic [1:0]  sh_state  [MAX_TASKS];
    logic [17:0] sh_cnt    [MAX_TASKS];

    t_result step_results[$];
    t_result due_results[$];
    t_row    dir_rows[$];
    int      n_err;
    bit      calm;
    bit      hold_req;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("** periodic_task_scheduler_top: FAILED **");
        $finish;
    end

    // results this transfer causes, from the shadow state
    function automatic void schedule_step(input t_item it);
        t_result r;
        step_results.delete();
        r.kind   = KIND_CREATE;
        r.status = CST_OK;
        r.id     = 3'd0;
        r.last   = 1'b1;
        case (it.op)
            OP_CREATE: begin
                if (!it.fn) begin
                    r.status = CST_NOFUNC;
                end else if (it.period > hyper_reg) begin
                    r.status = CST_PERIOD;
                end else if (n_tasks >= MAX_TASKS) begin
                    r.status = CST_FULL;
                end else begin
                    r.id               = n_tasks[2:0];
                    sh_period[n_tasks] = it.period;
                    sh_delay[n_tasks]  = it.delay;
                    sh_state[n_tasks]  = (it.init == TS_UNUSED) ? TS_BLOCKED : it.init;
                    sh_cnt[n_tasks]    = {2'b00, tick_step_reg};
                    n_tasks++;
                end
                step_results.push_back(r);
            end
            OP_TICK: begin
                for (int i = 0; i < n_tasks; i++) begin
                    if (sh_state[i] != TS_SUSPENDED) begin
                        if (sh_cnt[i] >= {2'b00, sh_period[i]}) begin
                            sh_state[i] = TS_READY;
                            sh_cnt[i]   = {2'b00, tick_step_reg} + {10'd0, sh_delay[i]};
                        end else begin
                            sh_cnt[i] = sh_cnt[i] + {2'b00, tick_step_reg};
                        end
                    end
                end
                r.kind = KIND_TICK;
                step_results.push_back(r);
            end
            OP_DISPATCH: begin
                r.kind = KIND_DISP;
                r.last = 1'b0;
                for (int i = 0; i < n_tasks; i++) begin
                    if (sh_state[i] == TS_READY) begin
                        sh_state[i] = TS_BLOCKED;
                        r.id = i[2:0];
                        step_results.push_back(r);
                    end
                end
                if (step_results.size() == 0) begin
                    r.kind = KIND_NONE;
                    r.id   = 3'd0;
                    r.last = 1'b1;
                    step_results.push_back(r);
                end else begin
                    step_results[step_results.size() - 1].last = 1'b1;
                end
            end
            default: ;
        endcase
    endfunction

    function automatic t_item mk_item(input logic [1:0] op, input logic fn,
                                      input logic [15:0] period, input logic [1:0] init,
                                      input logic [7:0] delay);
        t_item it;
        it.op     = op;
        it.fn     = fn;
        it.period = period;
        it.init   = init;
        it.delay  = delay;
        return it;
    endfunction

    function automatic t_row r_item(input logic [1:0] op, input logic fn,
                                    input logic [15:0] period, input logic [1:0] init,
                                    input logic [7:0] delay);
        t_row r;
        r        = '0;
        r.it     = mk_item(op, fn, period, init, delay);
        return r;
    endfunction

    function automatic t_row r_want(input logic [1:0] op, input logic fn,
                                    input logic [15:0] period, input logic [1:0] init,
                                    input logic [7:0] delay, input logic [1:0] kind,
                                    input logic [1:0] status, input logic [2:0] id);
        t_row r;
        r             = r_item(op, fn, period, init, delay);
        r.typed       = 1'b1;
        r.want.kind   = kind;
        r.want.status = status;
        r.want.id     = id;
        r.want.last   = 1'b1;
        return r;
    endfunction

    function automatic t_row r_cfg(input logic idx, input logic [15:0] data);
        t_row r;
        r          = '0;
        r.is_cfg   = 1'b1;
        r.cfg_idx  = idx;
        r.cfg_data = data;
        return r;
    endfunction

    function automatic t_item rand_item();
        int    pick;
        t_item it;
        pick      = $urandom_range(99);
        it.fn     = ($urandom_range(9) != 0);
        it.period = ($urandom_range(1) != 0) ? 16'($urandom_range(12)) : 16'($urandom);
        it.init   = 2'($urandom_range(3));
        it.delay  = 8'($urandom_range(255));
        if (pick < 45)
            it.op = OP_TICK;
        else if (pick < 80)
            it.op = OP_DISPATCH;
        else if (pick < 95)
            it.op = OP_CREATE;
        else
            it.op = OP_UNUSED;
        return it;
    endfunction

    task automatic send_item(input t_item it, input bit typed, input t_result want);
        while (!calm && $urandom_range(99) < 28) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid      = 1'b1;
        i_op            = it.op;
        i_has_function  = it.fn;
        i_period        = it.period;
        i_initial_state = it.init;
        i_extra_delay   = it.delay;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        schedule_step(it);
        if (typed)
            due_results.push_back(want);
        else
            foreach (step_results[k]) due_results.push_back(step_results[k]);
        @(negedge i_clk);
    endtask

    // wait for every pending result, then let a silent walk finish
    task automatic settle();
        i_in_valid = 1'b0;
        while (due_results.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [15:0] data);
        settle();
        i_cfg_we    = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        if (idx == REG_TICK_STEP)
            tick_step_reg = data;
        else
            hyper_reg = data;
    endtask

    // receiver side: random stalls, one long hold-off on request
    initial begin
        int hold_left;
        bit held;
        hold_left   = 0;
        held        = 1'b0;
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req && !held) begin
                held      = 1'b1;
                hold_left = 200;
            end
            if (hold_left > 0) begin
                i_out_stall = 1'b1;
                hold_left--;
            end else begin
                i_out_stall = !calm && ($urandom_range(99) < 28);
            end
        end
    end

    always @(posedge i_clk) begin : result_check
        t_result w;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (due_results.size() == 0) begin
                $error("unexpected result: kind %0d status %0d task_id %0d last %0d",
                       o_kind, o_status, o_task_id, o_last);
                n_err++;
            end else begin
                w = due_results.pop_front();
                if (o_kind !== w.kind) begin
                    $error("kind: expected %0d, got %0d", w.kind, o_kind);
                    n_err++;
                end
                if (o_status !== w.status) begin
                    $error("status: expected %0d, got %0d", w.status, o_status);
                    n_err++;
                end
                if (o_task_id !== w.id) begin
                    $error("task_id: expected %0d, got %0d", w.id, o_task_id);
                    n_err++;
                end
                if (o_last !== w.last) begin
                    $error("last: expected %0d, got %0d", w.last, o_last);
                    n_err++;
                end
            end
        end
    end

    initial begin
        t_item       it;
        t_result     none;
        int          n_items;
        logic [15:0] ph_step;
        logic [15:0] ph_hyper;

        n_err           = 0;
        calm            = 1'b0;
        hold_req        = 1'b0;
        none            = '0;
        n_tasks         = 0;
        tick_step_reg   = 16'd1;
        hyper_reg       = 16'hFFFF;
        i_rst_n         = 1'b0;
        i_in_valid      = 1'b0;
        i_op            = OP_TICK;
        i_has_function  = 1'b0;
        i_period        = 16'd0;
        i_initial_state = TS_SUSPENDED;
        i_extra_delay   = 8'd0;
        i_cfg_we        = 1'b0;
        i_cfg_index     = REG_TICK_STEP;
        i_cfg_data      = 16'd0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // empty table, check order, extremes, every op
        dir_rows.push_back(r_want(OP_DISPATCH, 0, 0, 0, 0, KIND_NONE, CST_OK, 0));
        dir_rows.push_back(r_want(OP_TICK, 0, 0, 0, 0, KIND_TICK, CST_OK, 0));
        dir_rows.push_back(r_want(OP_CREATE, 0, 16'hFFFF, 1, 0, KIND_CREATE, CST_NOFUNC, 0));
        dir_rows.push_back(r_want(OP_CREATE, 1, 0, TS_READY, 0, KIND_CREATE, CST_OK, 0));
        dir_rows.push_back(r_want(OP_CREATE, 1, 16'hFFFF, TS_BLOCKED, 8'hFF,
                                  KIND_CREATE, CST_OK, 1));
        dir_rows.push_back(r_item(OP_UNUSED, 1, 16'h5A5A, 3, 8'hA5));
        dir_rows.push_back(r_cfg(REG_HYPER, 16'd100));
        dir_rows.push_back(r_want(OP_CREATE, 1, 16'd101, 1, 0, KIND_CREATE, CST_PERIOD, 0));
        dir_rows.push_back(r_want(OP_CREATE, 0, 16'd200, 1, 0, KIND_CREATE, CST_NOFUNC, 0));
        dir_rows.push_back(r_want(OP_CREATE, 1, 16'd100, TS_UNUSED, 3,
                                  KIND_CREATE, CST_OK, 2));
        dir_rows.push_back(r_want(OP_CREATE, 1, 16'd5, TS_SUSPENDED, 1,
                                  KIND_CREATE, CST_OK, 3));
        dir_rows.push_back(r_want(OP_TICK, 0, 0, 0, 0, KIND_TICK, CST_OK, 0));
        dir_rows.push_back(r_item(OP_DISPATCH, 0, 0, 0, 0));
        dir_rows.push_back(r_item(OP_CREATE, 1, 16'd2, TS_READY, 0));
        dir_rows.push_back(r_item(OP_CREATE, 1, 16'd7, TS_BLOCKED, 8'd200));
        dir_rows.push_back(r_item(OP_CREATE, 1, 16'd1, TS_READY, 8'd7));
        dir_rows.push_back(r_item(OP_CREATE, 1, 16'd3, TS_BLOCKED, 8'd2));
        dir_rows.push_back(r_want(OP_CREATE, 1, 16'd50, 2, 0, KIND_CREATE, CST_FULL, 0));
        dir_rows.push_back(r_want(OP_CREATE, 1, 16'hFFFF, 2, 0, KIND_CREATE, CST_PERIOD, 0));
        dir_rows.push_back(r_item(OP_DISPATCH, 0, 0, 0, 0));
        // counters frozen, reload gives just the delay
        dir_rows.push_back(r_cfg(REG_TICK_STEP, 16'd0));
        dir_rows.push_back(r_item(OP_TICK, 0, 0, 0, 0));
        dir_rows.push_back(r_item(OP_DISPATCH, 0, 0, 0, 0));
        dir_rows.push_back(r_item(OP_TICK, 0, 0, 0, 0));
        dir_rows.push_back(r_item(OP_DISPATCH, 0, 0, 0, 0));
        dir_rows.push_back(r_cfg(REG_TICK_STEP, 16'hFFFF));
        dir_rows.push_back(r_item(OP_TICK, 0, 0, 0, 0));
        dir_rows.push_back(r_item(OP_TICK, 0, 0, 0, 0));
        dir_rows.push_back(r_item(OP_DISPATCH, 0, 0, 0, 0));

        foreach (dir_rows[k]) begin
            if (dir_rows[k].is_cfg)
                write_reg(dir_rows[k].cfg_idx, dir_rows[k].cfg_data);
            else
                send_item(dir_rows[k].it, dir_rows[k].typed, dir_rows[k].want);
        end

        for (int p = 0; p < 7; p++) begin
            case (p)
                0: begin ph_step = 16'd1;     ph_hyper = 16'hFFFF; end
                1: begin ph_step = 16'd2;     ph_hyper = 16'd9;    end
                2: begin ph_step = 16'd0;     ph_hyper = 16'd0;    end
                3: begin ph_step = 16'hFFFF;  ph_hyper = 16'hFFFF; end
                4: begin
                    ph_step  = 16'($urandom_range(65535));
                    ph_hyper = 16'($urandom_range(65535));
                end
                5: begin ph_step = 16'd1;     ph_hyper = 16'd100;  end
                default: begin
                    ph_step  = 16'($urandom_range(16, 1));
                    ph_hyper = 16'($urandom_range(65535));
                end
            endcase
            write_reg(REG_TICK_STEP, ph_step);
            write_reg(REG_HYPER, ph_hyper);
            calm = (p == 2);
            // output held off while transfers keep coming, so the input backs up
            if (p == 4)
                hold_req = 1'b1;
            n_items = 0;
            while (n_items < PHASE_ITEMS) begin
                it = rand_item();
                send_item(it, 1'b0, none);
                if (it.op != OP_UNUSED)
                    n_items++;
            end
        end

        settle();
        if (n_err == 0)
            $display("** periodic_task_scheduler_top: PASSED **");
        else
            $display("** periodic_task_scheduler_top: FAILED **");
        $finish;
    end

endmodule
